// ===== sv/sts_pkg.sv =====
// sts_pkg: shared types, codes, keyword table and character class helpers
// for the source token scanner; no dependencies
package sts_pkg;

  localparam int unsigned LINE_BITS_DEF     = 16;
  localparam int unsigned KEYWORD_COUNT_DEF = 9;
  localparam int unsigned KW_TABLE_SIZE     = 16;
  localparam int unsigned KW_PREFIX_BYTES   = 5;
  localparam int unsigned TOKEN_LINE_W      = 16;
  localparam int unsigned FIFO_DEPTH        = 4;
  localparam int unsigned MAX_LEN_W         = 6;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 6'd39;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [3:0] {
    TOK_ID     = 4'd0,
    TOK_KW     = 4'd1,
    TOK_NUM    = 4'd2,
    TOK_DELIM  = 4'd3,
    TOK_REL    = 4'd4,
    TOK_REL_EQ = 4'd5,
    TOK_SLASH  = 4'd6,
    TOK_STR    = 4'd7,
    TOK_LONG   = 4'd8,
    TOK_BAD    = 4'd9,
    TOK_EOF    = 4'd10
  } tok_class_e;

  typedef enum logic [7:0] {
    MODE_IDLE    = 8'b0000_0001,
    MODE_IDENT   = 8'b0000_0010,
    MODE_NUMBER  = 8'b0000_0100,
    MODE_REL     = 8'b0000_1000,
    MODE_SLASH   = 8'b0001_0000,
    MODE_COMMENT = 8'b0010_0000,
    MODE_STRING  = 8'b0100_0000,
    MODE_WIDE    = 8'b1000_0000
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]              token_class;
    logic [3:0]              keyword_index;
    logic [7:0]              first_byte;
    logic [7:0]              second_byte;
    logic [TOKEN_LINE_W-1:0] token_line;
    logic [7:0]              token_length;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  item1;
    out_item_t  item0;
  } push_t;

  // byte 0 of each entry holds the first character
  localparam logic [8*KW_PREFIX_BYTES-1:0] KW_TEXT [KW_TABLE_SIZE] = '{
    40'("fi"), 40'("esle"), 40'("rof"), 40'("elihw"), 40'("od"),
    40'("tni"), 40'("daer"), 40'("etirw"), 40'("niam"),
    40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0
  };

  localparam logic [2:0] KW_LEN [KW_TABLE_SIZE] = '{
    3'd2, 3'd4, 3'd3, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5, 3'd4,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_single(input logic [7:0] b);
    return b inside {"+", "-", "*", "%", "(", ")", "{", "}", ";", ",", ":"};
  endfunction

  function automatic logic is_rel(input logic [7:0] b);
    return b inside {">", "<", "=", "!"};
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? (b + 8'd32) : b;
  endfunction

endpackage

// ===== sv/sts_scan_core.sv =====
// sts_scan_core: scan state registers and the per-byte next-state and
// token record logic; depends on sts_pkg
module sts_scan_core import sts_pkg::*; #(
  parameter int unsigned LINE_BITS     = LINE_BITS_DEF,
  parameter int unsigned KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  in_item_t             item_i,
  input  logic [MAX_LEN_W-1:0] max_len_i,
  output push_t                push_o
);

  scan_mode_e                     mode_q, mode_d;
  logic [LINE_BITS-1:0]           line_q, line_d;
  logic [LINE_BITS-1:0]           sline_q, sline_d;
  logic [7:0]                     len_q, len_d;
  logic [8*KW_PREFIX_BYTES-1:0]   prefix_q, prefix_d;
  logic [7:0]                     held_q, held_d;
  logic                           star_q, star_d;
  logic                           long_q, long_d;

  logic [7:0]                     b;
  logic [7:0]                     b_low;
  logic [7:0]                     len_inc;
  logic [LINE_BITS-1:0]           line_nl;
  logic [TOKEN_LINE_W-1:0]        line_old;
  logic [TOKEN_LINE_W-1:0]        line_new;

  logic                           kw_hit;
  logic [3:0]                     kw_idx;

  scan_mode_e                     idle_mode;
  logic                           idle_emit;
  out_item_t                      idle_res;

  logic                           use_idle;
  logic                           emit_a, emit_b;
  out_item_t                      res_a, res_b, ident_res;

  assign b        = item_i.char_code;
  assign b_low    = to_lower(b);
  assign len_inc  = (len_q == 8'hFF) ? len_q : len_q + 8'd1;
  assign line_nl  = (b == CH_NL && !(&line_q)) ? line_q + 1'b1 : line_q;
  assign line_old = TOKEN_LINE_W'(sline_q);
  assign line_new = TOKEN_LINE_W'(line_nl);

  // keyword match, lowest index wins
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = KW_TABLE_SIZE - 1; k >= 0; k--) begin
      if (k < KEYWORD_COUNT && KW_LEN[k] != 3'd0 && len_q == {5'd0, KW_LEN[k]}
          && prefix_q == KW_TEXT[k]) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    end
  end

  always_comb begin
    ident_res              = '0;
    ident_res.token_line   = line_old;
    ident_res.token_length = len_q;
    if (long_q) begin
      ident_res.token_class = TOK_LONG;
    end else if (kw_hit) begin
      ident_res.token_class   = TOK_KW;
      ident_res.keyword_index = kw_idx;
    end else begin
      ident_res.token_class = TOK_ID;
    end
  end

  // byte arriving between tokens
  always_comb begin
    idle_mode             = MODE_IDLE;
    idle_emit             = 1'b0;
    idle_res              = '0;
    idle_res.token_line   = line_new;
    idle_res.first_byte   = b;
    idle_res.token_length = 8'd1;
    if (b == CH_SPACE || b == CH_TAB || b == CH_NL) begin
      idle_mode = MODE_IDLE;
    end else if (is_alpha(b)) begin
      idle_mode = MODE_IDENT;
    end else if (is_digit(b)) begin
      idle_mode = MODE_NUMBER;
    end else if (is_single(b)) begin
      idle_emit            = 1'b1;
      idle_res.token_class = TOK_DELIM;
    end else if (is_rel(b)) begin
      idle_mode = MODE_REL;
    end else if (b == CH_SLASH) begin
      idle_mode = MODE_SLASH;
    end else if (b == CH_QUOTE) begin
      idle_mode = MODE_STRING;
    end else if (b[7]) begin
      idle_mode = MODE_WIDE;
    end else begin
      idle_emit            = 1'b1;
      idle_res.token_class = TOK_BAD;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    sline_d  = sline_q;
    len_d    = len_q;
    prefix_d = prefix_q;
    held_d   = held_q;
    star_d   = star_q;
    long_d   = long_q;
    use_idle = 1'b0;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    res_a    = '0;
    res_a.token_line = line_old;
    res_b    = '0;

    if (item_i.end_of_input) begin
      unique case (mode_q)
        MODE_IDENT: begin
          emit_a = 1'b1;
          res_a  = ident_res;
        end
        MODE_NUMBER: begin
          emit_a             = 1'b1;
          res_a.token_class  = TOK_NUM;
          res_a.token_length = len_q;
        end
        MODE_REL: begin
          emit_a             = 1'b1;
          res_a.token_class  = TOK_REL;
          res_a.first_byte   = held_q;
          res_a.token_length = 8'd1;
        end
        MODE_SLASH: begin
          emit_a             = 1'b1;
          res_a.token_class  = TOK_SLASH;
          res_a.first_byte   = CH_SLASH;
          res_a.token_length = 8'd1;
        end
        MODE_STRING: begin
          emit_a             = 1'b1;
          res_a.token_class  = TOK_STR;
          res_a.token_length = len_q;
        end
        MODE_WIDE: begin
          emit_a             = 1'b1;
          res_a.token_class  = TOK_BAD;
          res_a.first_byte   = held_q;
          res_a.token_length = 8'd1;
        end
        MODE_IDLE, MODE_COMMENT: begin
          emit_a = 1'b0;
        end
        default: begin
          emit_a = 1'b0;
        end
      endcase
      emit_b            = 1'b1;
      res_b.token_class = TOK_EOF;
      res_b.token_line  = line_old;
      mode_d   = MODE_IDLE;
      line_d   = LINE_BITS'(1);
      sline_d  = LINE_BITS'(1);
      len_d    = '0;
      prefix_d = '0;
      held_d   = '0;
      star_d   = 1'b0;
      long_d   = 1'b0;
    end else begin
      line_d = line_nl;
      unique case (mode_q)
        MODE_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            for (int i = 0; i < KW_PREFIX_BYTES; i++) begin
              if (len_q == 8'(i)) prefix_d[8*i +: 8] = b_low;
            end
            len_d  = len_inc;
            long_d = long_q | (len_inc > {2'd0, max_len_i});
          end else begin
            emit_a   = 1'b1;
            res_a    = ident_res;
            use_idle = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(b)) begin
            len_d = len_inc;
          end else begin
            emit_a             = 1'b1;
            res_a.token_class  = TOK_NUM;
            res_a.token_length = len_q;
            use_idle           = 1'b1;
          end
        end
        MODE_REL: begin
          emit_a           = 1'b1;
          res_a.first_byte = held_q;
          if (b == CH_EQ) begin
            res_a.token_class  = TOK_REL_EQ;
            res_a.second_byte  = CH_EQ;
            res_a.token_length = 8'd2;
            mode_d             = MODE_IDLE;
          end else begin
            res_a.token_class  = TOK_REL;
            res_a.token_length = 8'd1;
            use_idle           = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (b == CH_STAR) begin
            mode_d = MODE_COMMENT;
            star_d = 1'b0;
          end else begin
            emit_a             = 1'b1;
            res_a.token_class  = TOK_SLASH;
            res_a.first_byte   = CH_SLASH;
            res_a.token_length = 8'd1;
            use_idle           = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (star_q && b == CH_SLASH) begin
            mode_d = MODE_IDLE;
            star_d = 1'b0;
          end else begin
            star_d = (b == CH_STAR);
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            emit_a             = 1'b1;
            res_a.token_class  = TOK_STR;
            res_a.token_length = len_q;
            mode_d             = MODE_IDLE;
          end else begin
            len_d = len_inc;
          end
        end
        MODE_WIDE: begin
          emit_a             = 1'b1;
          res_a.token_class  = TOK_BAD;
          res_a.first_byte   = held_q;
          res_a.second_byte  = b;
          res_a.token_length = 8'd2;
          mode_d             = MODE_IDLE;
        end
        MODE_IDLE: begin
          use_idle = 1'b1;
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase

      if (use_idle) begin
        mode_d  = idle_mode;
        sline_d = line_nl;
        emit_b  = idle_emit;
        res_b   = idle_res;
        unique case (idle_mode)
          MODE_IDENT: begin
            len_d    = 8'd1;
            prefix_d = {{(8*KW_PREFIX_BYTES-8){1'b0}}, b_low};
            long_d   = (max_len_i == '0);
          end
          MODE_NUMBER: len_d  = 8'd1;
          MODE_STRING: len_d  = 8'd0;
          MODE_REL:    held_d = b;
          MODE_WIDE:   held_d = b;
          default:     held_d = held_q;
        endcase
      end
    end
  end

  always_comb begin
    push_o = '0;
    if (step_i) begin
      if (emit_a) begin
        push_o.item0 = res_a;
        if (emit_b) begin
          push_o.item1      = res_b;
          push_o.item1.last = 1'b1;
          push_o.count      = 2'd2;
        end else begin
          push_o.item0.last = 1'b1;
          push_o.count      = 2'd1;
        end
      end else if (emit_b) begin
        push_o.item0      = res_b;
        push_o.item0.last = 1'b1;
        push_o.count      = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      line_q   <= LINE_BITS'(1);
      sline_q  <= LINE_BITS'(1);
      len_q    <= '0;
      prefix_q <= '0;
      held_q   <= '0;
      star_q   <= 1'b0;
      long_q   <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      line_q   <= line_d;
      sline_q  <= sline_d;
      len_q    <= len_d;
      prefix_q <= prefix_d;
      held_q   <= held_d;
      star_q   <= star_d;
      long_q   <= long_d;
    end
  end

endmodule

// ===== sv/sts_result_fifo.sv =====
// sts_result_fifo: small result queue that takes up to two token records per
// cycle and hands out one per transfer; depends on sts_pkg
module sts_result_fifo import sts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  out_item_t         mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [PtrW-1:0]   wr_next;
  logic              pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= CntW'(FIFO_DEPTH - 2));
  assign wr_next     = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.item0;
    if (push_i.count == 2'd2) mem_q[wr_next] <= push_i.item1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/source_token_scanner.sv =====
// source_token_scanner: top level with input register, scan core and result queue
// depends on sts_pkg, sts_scan_core, sts_result_fifo
// a byte passes the input register, then the scan core writes its records into the result queue
// throughput: one byte per cycle while the result queue has room; output side drains one record per
// cycle while out_ready_i is high, so a byte that closes a token and forms another leaves two records
// reset: asynchronous, clears input register, scan state, queue and sets max_len_q to 39
module source_token_scanner import sts_pkg::*; #(
  parameter int unsigned LINE_BITS     = LINE_BITS_DEF,
  parameter int unsigned KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [MAX_LEN_W-1:0] cfg_wdata_i
);

  logic                 in_valid_q;
  in_item_t             in_item_q;
  logic [MAX_LEN_W-1:0] max_len_q;
  logic                 room;
  logic                 step;
  push_t                push;

  assign step       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      max_len_q  <= MAX_LEN_RESET;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_item_q <= in_item_i;
  end

  sts_scan_core #(
    .LINE_BITS     (LINE_BITS),
    .KEYWORD_COUNT (KEYWORD_COUNT)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .max_len_i (max_len_q),
    .push_o    (push)
  );

  sts_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sv/sts_checker.sv =====
// sts_checker: port-level assertions for source_token_scanner and its bind
// depends on sts_pkg
module sts_checker import sts_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.token_class == TOK_EOF |->
      out_item_o.last && out_item_o.token_length == 8'd0)
    else $error("end of input record malformed");

  a_kw_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.token_class != TOK_KW |-> out_item_o.keyword_index == 4'd0)
    else $error("keyword index on non-keyword token");

  a_rel_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.token_class == TOK_REL_EQ |->
      out_item_o.second_byte == CH_EQ && out_item_o.token_length == 8'd2)
    else $error("relational with equals malformed");

endmodule

bind source_token_scanner sts_checker u_sts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== sim/sts_token_checker.sv =====
// sts_token_checker: watches the byte and token channels of the source token scanner,
// predicts every token record and compares it field by field
// depends on sts_pkg
module sts_token_checker import sts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_item_i,
  input  logic                 cfg_we_i,
  input  logic [MAX_LEN_W-1:0] cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  string kw_word [9] = '{"if", "else", "for", "while", "do", "int", "read", "write", "main"};

  scan_mode_e              mode;
  logic [TOKEN_LINE_W-1:0] line_cnt;
  logic [TOKEN_LINE_W-1:0] tok_line;
  logic [7:0]              len_cnt;
  logic [4:0][7:0]         prefix;
  logic [7:0]              held;
  logic                    star_seen;
  logic                    too_long;
  logic [MAX_LEN_W-1:0]    max_len;

  out_item_t   token_q [$];
  out_item_t   new_tok [2];
  int unsigned step_n;
  int unsigned fails = 0;
  int unsigned pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_num_char(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_delim(logic [7:0] b);
    case (b)
      "+", "-", "*", "%", "(", ")", "{", "}", ";", ",", ":": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_rel_char(logic [7:0] b);
    case (b)
      ">", "<", "=", "!": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_scan();
    mode      = MODE_IDLE;
    line_cnt  = 1;
    tok_line  = 1;
    len_cnt   = '0;
    prefix    = '0;
    held      = '0;
    star_seen = 1'b0;
    too_long  = 1'b0;
  endtask

  task automatic emit(tok_class_e cls, logic [3:0] kw, logic [7:0] fb, logic [7:0] sb,
                      logic [7:0] len);
    out_item_t r;
    r.token_class   = cls;
    r.keyword_index = kw;
    r.first_byte    = fb;
    r.second_byte   = sb;
    r.token_line    = tok_line;
    r.token_length  = len;
    r.last          = 1'b0;
    new_tok[step_n] = r;
    step_n++;
  endtask

  task automatic add_word_char(logic [7:0] b);
    logic [7:0] low;
    low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (len_cnt < 5) prefix[len_cnt] = low;
    if (len_cnt != 8'hFF) len_cnt++;
    if (len_cnt > max_len) too_long = 1'b1;
  endtask

  task automatic close_word();
    int k;
    int i;
    bit hit;
    if (too_long) begin
      emit(TOK_LONG, 0, 0, 0, len_cnt);
      return;
    end
    for (k = 0; k < 9; k++) begin
      if (kw_word[k].len() == len_cnt) begin
        hit = 1'b1;
        for (i = 0; i < kw_word[k].len(); i++)
          if (prefix[i] != kw_word[k][i]) hit = 1'b0;
        if (hit) begin
          emit(TOK_KW, 4'(k), 0, 0, len_cnt);
          return;
        end
      end
    end
    emit(TOK_ID, 0, 0, 0, len_cnt);
  endtask

  // byte seen between tokens
  task automatic start_byte(logic [7:0] b);
    mode     = MODE_IDLE;
    tok_line = line_cnt;
    if (b == CH_SPACE || b == CH_TAB || b == CH_NL) return;
    if (is_letter(b)) begin
      mode     = MODE_IDENT;
      len_cnt  = '0;
      prefix   = '0;
      too_long = 1'b0;
      add_word_char(b);
    end else if (is_num_char(b)) begin
      mode    = MODE_NUMBER;
      len_cnt = 1;
    end else if (is_delim(b)) begin
      emit(TOK_DELIM, 0, b, 0, 1);
    end else if (is_rel_char(b)) begin
      mode = MODE_REL;
      held = b;
    end else if (b == CH_SLASH) begin
      mode = MODE_SLASH;
    end else if (b == CH_QUOTE) begin
      mode    = MODE_STRING;
      len_cnt = '0;
    end else if (b[7]) begin
      mode = MODE_WIDE;
      held = b;
    end else begin
      emit(TOK_BAD, 0, b, 0, 1);
    end
  endtask

  task automatic predict(in_item_t it);
    logic [7:0] b;
    int i;
    b      = it.char_code;
    step_n = 0;
    if (it.end_of_input) begin
      case (mode)
        MODE_IDENT:  close_word();
        MODE_NUMBER: emit(TOK_NUM, 0, 0, 0, len_cnt);
        MODE_REL:    emit(TOK_REL, 0, held, 0, 1);
        MODE_SLASH:  emit(TOK_SLASH, 0, CH_SLASH, 0, 1);
        MODE_STRING: emit(TOK_STR, 0, 0, 0, len_cnt);
        MODE_WIDE:   emit(TOK_BAD, 0, held, 0, 1);
        default: ;
      endcase
      emit(TOK_EOF, 0, 0, 0, 0);
      clear_scan();
    end else begin
      if (b == CH_NL && line_cnt != '1) line_cnt++;
      case (mode)
        MODE_IDENT: begin
          if (is_letter(b) || is_num_char(b)) add_word_char(b);
          else begin
            close_word();
            start_byte(b);
          end
        end
        MODE_NUMBER: begin
          if (is_num_char(b)) begin
            if (len_cnt != 8'hFF) len_cnt++;
          end else begin
            emit(TOK_NUM, 0, 0, 0, len_cnt);
            start_byte(b);
          end
        end
        MODE_REL: begin
          if (b == CH_EQ) begin
            emit(TOK_REL_EQ, 0, held, CH_EQ, 2);
            mode = MODE_IDLE;
          end else begin
            emit(TOK_REL, 0, held, 0, 1);
            start_byte(b);
          end
        end
        MODE_SLASH: begin
          if (b == CH_STAR) begin
            mode      = MODE_COMMENT;
            star_seen = 1'b0;
          end else begin
            emit(TOK_SLASH, 0, CH_SLASH, 0, 1);
            start_byte(b);
          end
        end
        MODE_COMMENT: begin
          if (star_seen && b == CH_SLASH) begin
            mode      = MODE_IDLE;
            star_seen = 1'b0;
          end else begin
            star_seen = (b == CH_STAR);
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            emit(TOK_STR, 0, 0, 0, len_cnt);
            mode = MODE_IDLE;
          end else if (len_cnt != 8'hFF) begin
            len_cnt++;
          end
        end
        MODE_WIDE: begin
          emit(TOK_BAD, 0, held, b, 2);
          mode = MODE_IDLE;
        end
        default: start_byte(b);
      endcase
    end
    if (step_n > 0) new_tok[step_n-1].last = 1'b1;
    for (i = 0; i < step_n; i++) token_q.push_back(new_tok[i]);
  endtask

  task automatic cmp_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fails++;
    end
  endtask

  task automatic check_token(out_item_t got);
    out_item_t want;
    if (token_q.size() == 0) begin
      $error("token_class: expected none, actual %0d", got.token_class);
      fails++;
      return;
    end
    want = token_q.pop_front();
    cmp_field("token_class", want.token_class, got.token_class);
    cmp_field("keyword_index", want.keyword_index, got.keyword_index);
    cmp_field("first_byte", want.first_byte, got.first_byte);
    cmp_field("second_byte", want.second_byte, got.second_byte);
    cmp_field("token_line", want.token_line, got.token_line);
    cmp_field("token_length", want.token_length, got.token_length);
    cmp_field("last", want.last, got.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      max_len = MAX_LEN_RESET;
      token_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_token(out_item_i);
      if (cfg_we_i) max_len = cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict(in_item_i);
      pending = token_q.size();
    end
  end

endmodule

// ===== sim/source_token_scanner_tb.sv =====
// source_token_scanner_tb: drives source text through the token scanner with random
// stalls on both sides and several identifier limits; checking is in sts_token_checker
// depends on sts_pkg, source_token_scanner, sts_token_checker
module source_token_scanner_tb;
  import sts_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [MAX_LEN_W-1:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned sent_items    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned ident_limit   = MAX_LEN_RESET;

  string      kw_list [9] = '{"if", "else", "for", "while", "do", "int", "read", "write", "main"};
  logic [7:0] frag_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  source_token_scanner u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  sts_token_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(logic [7:0] b, logic eoi);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid                <= 1'b1;
    in_item.char_code       <= b;
    in_item.end_of_input    <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_eof();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_ident_limit(int unsigned v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= MAX_LEN_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    ident_limit = v;
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_word_char();
    return ($urandom_range(3) == 0) ? rand_digit() : rand_letter();
  endfunction

  task automatic build_fragment();
    int unsigned kind;
    int unsigned r;
    int unsigned n;
    int unsigned k;
    int unsigned i;
    logic [7:0]  c;
    frag_q.delete();
    kind = $urandom_range(99);
    r    = $urandom_range(99);
    if (kind < 22) begin
      if (r < 80) n = $urandom_range(10, 1);
      else if (r < 97) n = $urandom_range(ident_limit + 2, (ident_limit > 2) ? ident_limit - 2 : 1);
      else n = $urandom_range(262, 250);
      frag_q.push_back(rand_letter());
      for (i = 1; i < n; i++) frag_q.push_back(rand_word_char());
    end else if (kind < 32) begin
      k = $urandom_range(8);
      for (i = 0; i < kw_list[k].len(); i++) begin
        c = kw_list[k][i];
        if ($urandom_range(1)) c = c ^ 8'h20;
        frag_q.push_back(c);
      end
      if (r < 25) frag_q.push_back(rand_word_char());
    end else if (kind < 44) begin
      n = (r < 97) ? $urandom_range(6, 1) : $urandom_range(262, 250);
      for (i = 0; i < n; i++) frag_q.push_back(rand_digit());
    end else if (kind < 54) begin
      case ($urandom_range(10))
        0: c = "+";  1: c = "-";  2: c = "*";  3: c = "%";  4: c = "(";
        5: c = ")";  6: c = "{";  7: c = "}";  8: c = ";";  9: c = ",";
        default: c = ":";
      endcase
      frag_q.push_back(c);
    end else if (kind < 64) begin
      case ($urandom_range(3))
        0: c = ">";  1: c = "<";  2: c = "=";
        default: c = "!";
      endcase
      frag_q.push_back(c);
      if (r < 50) frag_q.push_back(CH_EQ);
    end else if (kind < 68) begin
      frag_q.push_back(CH_SLASH);
    end else if (kind < 76) begin
      frag_q.push_back(CH_SLASH);
      frag_q.push_back(CH_STAR);
      n = $urandom_range(8);
      for (i = 0; i < n; i++) begin
        k = $urandom_range(9);
        if (k < 3) c = CH_STAR;
        else if (k < 5) c = CH_SLASH;
        else if (k < 6) c = CH_NL;
        else c = 8'($urandom_range(255));
        frag_q.push_back(c);
      end
      if (r >= 10) begin
        frag_q.push_back(CH_STAR);
        frag_q.push_back(CH_SLASH);
      end
    end else if (kind < 84) begin
      frag_q.push_back(CH_QUOTE);
      n = ($urandom_range(49) == 0) ? $urandom_range(262, 250) : $urandom_range(10);
      for (i = 0; i < n; i++) begin
        k = $urandom_range(9);
        if (k < 6) c = 8'($urandom_range(126, 32));
        else if (k < 7) c = CH_NL;
        else c = 8'($urandom_range(255));
        if (c == CH_QUOTE) c = CH_SPACE;
        frag_q.push_back(c);
      end
      if (r >= 10) frag_q.push_back(CH_QUOTE);
    end else if (kind < 88) begin
      case ($urandom_range(7))
        0: c = 8'h00;  1: c = 8'h0D;  2: c = "#";  3: c = "$";
        4: c = "@";    5: c = ".";    6: c = "?";
        default: c = 8'($urandom_range(127));
      endcase
      frag_q.push_back(c);
    end else if (kind < 93) begin
      frag_q.push_back(8'($urandom_range(255, 128)));
      frag_q.push_back(8'($urandom_range(255)));
    end else begin
      frag_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned stop_at;
    int unsigned keep;
    int unsigned i;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      build_fragment();
      if ($urandom_range(99) < 3) begin
        keep = $urandom_range(frag_q.size(), 1);
        for (i = 0; i < keep; i++) send_byte(frag_q[i], 1'b0);
        send_eof();
      end else begin
        foreach (frag_q[j]) send_byte(frag_q[j], 1'b0);
        case ($urandom_range(9))
          0, 1: send_byte(CH_SPACE, 1'b0);
          2:    send_byte(CH_TAB, 1'b0);
          3:    send_byte(CH_NL, 1'b0);
          default: ;
        endcase
        if ($urandom_range(99) < 2) send_eof();
      end
    end
    send_eof();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_idle_pct  = 13;
    sink_idle_pct = 70;
    send_text("If<=7!\n/ /*/*/\"");
    send_byte(8'h80, 1'b0);
    send_text("\";");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_text("a");
    send_eof();
    send_byte(8'h80, 1'b0);
    send_eof();
    run_random(480);

    set_ident_limit(63);
    src_idle_pct  = 70;
    sink_idle_pct = 13;
    run_random(500);

    set_ident_limit(1);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(250);
    wait_drained();
    run_random(250);

    set_ident_limit($urandom_range(62, 2));
    run_random(50);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
